// File: rtl/two_class_fifo_oldest_first_top_defines.svh
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_TOP_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define TCFO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define TCFO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tcfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcfo_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int STAMP_BITS   = 16;

  localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = STAMP_BITS + PAYLOAD_BITS;

  localparam int PAY_PORT_W   = 16;
  localparam int STAMP_PORT_W = 16;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ_ANY = 2'd1,
    OP_DEQ_C0  = 2'd2,
    OP_DEQ_C1  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_RESOLVE = 1'b1
  } state_t;

  typedef struct packed {
    logic             push;
    logic             pop;
  } qptr_cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [IDX_W-1:0] tail;
    logic             empty;
    logic             full;
  } qptr_stat_t;

  typedef struct packed {
    logic               we0;
    logic               we1;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
  } ram_cmd_t;

endpackage

`default_nettype wire

// File: rtl/tcfo_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcfo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/tcfo_qptr.sv
`timescale 1ns / 1ps
`default_nettype none

`include "two_class_fifo_oldest_first_top_defines.svh"

module tcfo_qptr (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tcfo_pkg::qptr_cmd_t cmd,
  output tcfo_pkg::qptr_stat_t     stat
);

  logic [tcfo_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [tcfo_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [tcfo_pkg::CNT_W:0]   tail_sum;

  always_comb begin
    tail_sum = {1'b0, {(tcfo_pkg::CNT_W - tcfo_pkg::IDX_W){1'b0}}, head_r}
               + {1'b0, count_r};
    if (tail_sum >= (tcfo_pkg::CNT_W + 1)'(tcfo_pkg::QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (tcfo_pkg::CNT_W + 1)'(tcfo_pkg::QUEUE_DEPTH);
    end
    stat.head  = head_r;
    stat.tail  = tail_sum[tcfo_pkg::IDX_W-1:0];
    stat.empty = (count_r == '0);
    stat.full  = (count_r == tcfo_pkg::CNT_W'(tcfo_pkg::QUEUE_DEPTH));
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      if (head_r == tcfo_pkg::IDX_W'(tcfo_pkg::QUEUE_DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + 1'b1;
      end
    end
    if (cmd.push && !cmd.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop && !cmd.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  `TCFO_ASSERT_NOW(a_no_push_full, cmd.push, !stat.full, "push into full queue")
  `TCFO_ASSERT_NOW(a_no_pop_empty, cmd.pop, !stat.empty, "pop from empty queue")
  `TCFO_ASSERT_NEXT(a_push_grows, cmd.push && !cmd.pop, count_r == $past(count_r) + 1'b1, "count did not grow on push")

endmodule

`default_nettype wire

// File: rtl/tcfo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "two_class_fifo_oldest_first_top_defines.svh"

module tcfo_ctrl (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [15:0]                         in_tdata,
  input  wire logic [2:0]                          in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [31:0]                              out_tdata,
  output logic [2:0]                               out_tuser,
  input  wire tcfo_pkg::qptr_stat_t                q0_stat,
  input  wire tcfo_pkg::qptr_stat_t                q1_stat,
  output tcfo_pkg::qptr_cmd_t                      q0_cmd,
  output tcfo_pkg::qptr_cmd_t                      q1_cmd,
  output tcfo_pkg::ram_cmd_t                       ram_cmd,
  input  wire logic [tcfo_pkg::ENTRY_W-1:0]        rd0,
  input  wire logic [tcfo_pkg::ENTRY_W-1:0]        rd1
);

  tcfo_pkg::state_t  state_r, state_nxt;
  tcfo_pkg::op_t     op_r, op_nxt, in_op;
  tcfo_pkg::status_t out_status_r, out_status_nxt;

  logic                              out_tvalid_r, out_tvalid_nxt;
  logic                              out_class_r, out_class_nxt;
  logic [tcfo_pkg::PAY_PORT_W-1:0]   out_payload_r, out_payload_nxt;
  logic [tcfo_pkg::STAMP_PORT_W-1:0] out_stamp_r, out_stamp_nxt;
  logic [tcfo_pkg::STAMP_BITS-1:0]   arrival_r, arrival_nxt, arrival_inc;

  logic                              out_free, accept, in_class, enq_full;
  logic [tcfo_pkg::STAMP_BITS-1:0]   s0, s1, s_diff;
  logic                              older1, take, take_cls;
  logic [tcfo_pkg::ENTRY_W-1:0]      take_entry;

  assign in_op       = tcfo_pkg::op_t'(in_tuser[1:0]);
  assign in_class    = in_tuser[2];
  assign out_free    = !out_tvalid_r || out_tready;
  assign in_tready   = (state_r == tcfo_pkg::S_IDLE) && out_free;
  assign accept      = in_tvalid && in_tready;
  assign arrival_inc = arrival_r + 1'b1;
  assign enq_full    = in_class ? q1_stat.full : q0_stat.full;

  // wrap-safe age order of the two heads
  assign s0     = rd0[tcfo_pkg::ENTRY_W-1 -: tcfo_pkg::STAMP_BITS];
  assign s1     = rd1[tcfo_pkg::ENTRY_W-1 -: tcfo_pkg::STAMP_BITS];
  assign s_diff = s1 - s0;
  assign older1 = (s_diff != '0) && s_diff[tcfo_pkg::STAMP_BITS-1];

  always_comb begin
    take     = 1'b0;
    take_cls = 1'b0;
    unique case (op_r)
      tcfo_pkg::OP_DEQ_C0: begin
        take     = !q0_stat.empty;
        take_cls = 1'b0;
      end
      tcfo_pkg::OP_DEQ_C1: begin
        take     = !q1_stat.empty;
        take_cls = 1'b1;
      end
      tcfo_pkg::OP_DEQ_ANY: begin
        // both empty reports class 0
        take     = !q0_stat.empty || !q1_stat.empty;
        take_cls = !q1_stat.empty && (q0_stat.empty || older1);
      end
      tcfo_pkg::OP_ENQ: begin
        take     = 1'b0;
        take_cls = 1'b0;
      end
    endcase
    take_entry = take_cls ? rd1 : rd0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcfo_pkg::S_IDLE: begin
        if (accept && in_op != tcfo_pkg::OP_ENQ) begin
          state_nxt = tcfo_pkg::S_RESOLVE;
        end
      end
      tcfo_pkg::S_RESOLVE: begin
        if (out_free) begin
          state_nxt = tcfo_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    ram_cmd         = '0;
    q0_cmd          = '0;
    q1_cmd          = '0;
    op_nxt          = op_r;
    arrival_nxt     = arrival_r;
    out_tvalid_nxt  = out_tready ? 1'b0 : out_tvalid_r;
    out_status_nxt  = out_status_r;
    out_class_nxt   = out_class_r;
    out_payload_nxt = out_payload_r;
    out_stamp_nxt   = out_stamp_r;
    ram_cmd.wdata   = {arrival_inc, tcfo_pkg::PAYLOAD_BITS'(in_tdata)};
    ram_cmd.waddr   = in_class ? q1_stat.tail : q0_stat.tail;
    unique case (state_r)
      tcfo_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt = in_op;
          if (in_op == tcfo_pkg::OP_ENQ) begin
            out_tvalid_nxt  = 1'b1;
            out_class_nxt   = in_class;
            out_payload_nxt = '0;
            if (enq_full) begin
              out_status_nxt = tcfo_pkg::ST_FULL;
              out_stamp_nxt  = '0;
            end else begin
              out_status_nxt = tcfo_pkg::ST_ENQUEUED;
              out_stamp_nxt  = tcfo_pkg::STAMP_PORT_W'(arrival_inc);
              arrival_nxt    = arrival_inc;
              ram_cmd.we0    = !in_class;
              ram_cmd.we1    = in_class;
              q0_cmd.push    = !in_class;
              q1_cmd.push    = in_class;
            end
          end else begin
            ram_cmd.re = 1'b1;
          end
        end
      end
      tcfo_pkg::S_RESOLVE: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_class_nxt  = take_cls;
          if (take) begin
            out_status_nxt  = tcfo_pkg::ST_DEQUEUED;
            out_payload_nxt = tcfo_pkg::PAY_PORT_W'(take_entry[tcfo_pkg::PAYLOAD_BITS-1:0]);
            out_stamp_nxt   =
              tcfo_pkg::STAMP_PORT_W'(take_entry[tcfo_pkg::ENTRY_W-1 -: tcfo_pkg::STAMP_BITS]);
            q0_cmd.pop      = !take_cls;
            q1_cmd.pop      = take_cls;
          end else begin
            out_status_nxt  = tcfo_pkg::ST_EMPTY;
            out_payload_nxt = '0;
            out_stamp_nxt   = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcfo_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
      arrival_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      arrival_r    <= arrival_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    out_status_r  <= out_status_nxt;
    out_class_r   <= out_class_nxt;
    out_payload_r <= out_payload_nxt;
    out_stamp_r   <= out_stamp_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_stamp_r, out_payload_r};
  assign out_tuser  = {out_class_r, out_status_r};

  `TCFO_ASSERT_NEXT(a_deq_resolves, accept && in_op != tcfo_pkg::OP_ENQ, state_r == tcfo_pkg::S_RESOLVE && !out_tvalid_r, "dequeue did not enter resolve with free output")
  `TCFO_ASSERT_NOW(a_one_pop, 1'b1, !(q0_cmd.pop && q1_cmd.pop), "both queues popped")
  `TCFO_ASSERT_NEXT(a_stamp_step, accept && in_op == tcfo_pkg::OP_ENQ && !enq_full, arrival_r == $past(arrival_r) + 1'b1, "arrival counter not advanced")

endmodule

`default_nettype wire

// File: rtl/two_class_fifo_oldest_first_top.sv
// The enqueue result is registered in the cycle after the transaction is accepted; a dequeue
// reads the heads from the store RAMs, then resolves and registers its result.
// Throughput: one enqueue per cycle; a dequeue holds further input until its result is
// registered. A stalled output holds further input.
// Reset (rst_n low, synchronous): heads, counts, arrival counter and output valid cleared;
// store RAM contents are left undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module two_class_fifo_oldest_first_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // payload[15:0]
  input  wire logic [2:0]  in_tuser,   // opcode[1:0], item_class[2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // out_payload[15:0], out_stamp[31:16]
  output logic [2:0]       out_tuser   // status[1:0], out_class[2]
);

  tcfo_pkg::qptr_stat_t              q0_stat, q1_stat;
  tcfo_pkg::qptr_cmd_t               q0_cmd, q1_cmd;
  tcfo_pkg::ram_cmd_t                ram_cmd;
  logic [tcfo_pkg::ENTRY_W-1:0]      rd0, rd1;

  tcfo_qptr u_qptr0 (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q0_cmd),
    .stat  (q0_stat)
  );

  tcfo_qptr u_qptr1 (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (q1_cmd),
    .stat  (q1_stat)
  );

  tcfo_ram #(
    .WIDTH (tcfo_pkg::ENTRY_W),
    .DEPTH (tcfo_pkg::QUEUE_DEPTH)
  ) u_store0 (
    .clk   (clk),
    .we    (ram_cmd.we0),
    .waddr (ram_cmd.waddr),
    .wdata (ram_cmd.wdata),
    .re    (ram_cmd.re),
    .raddr (q0_stat.head),
    .rdata (rd0)
  );

  tcfo_ram #(
    .WIDTH (tcfo_pkg::ENTRY_W),
    .DEPTH (tcfo_pkg::QUEUE_DEPTH)
  ) u_store1 (
    .clk   (clk),
    .we    (ram_cmd.we1),
    .waddr (ram_cmd.waddr),
    .wdata (ram_cmd.wdata),
    .re    (ram_cmd.re),
    .raddr (q1_stat.head),
    .rdata (rd1)
  );

  tcfo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .q0_stat    (q0_stat),
    .q1_stat    (q1_stat),
    .q0_cmd     (q0_cmd),
    .q1_cmd     (q1_cmd),
    .ram_cmd    (ram_cmd),
    .rd0        (rd0),
    .rd1        (rd1)
  );

endmodule

`default_nettype wire
